// ===== rtl/bwu_pkg.sv =====
// ----------------------------------------------------------------------------
// Barycentric weights package
// Shared defaults and widths for the barycentric weights unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bwu_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int WEIGHT_BITS    = 32;

endpackage : bwu_pkg

`default_nettype wire

// ===== rtl/bwu_front.sv =====
// ----------------------------------------------------------------------------
// Barycentric weights front end
// Edge differences, cross products, sums and magnitudes over four stages.
// ----------------------------------------------------------------------------
`default_nettype none

module bwu_front import bwu_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    localparam int DW = COORD_BITS + 1,
    localparam int PW = 2 * DW,
    localparam int UW = PW + 1,
    localparam int SW = UW + 1,
    localparam int NW = SW + FRAC_BITS
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    en,
    input  wire logic                    in_valid,
    input  wire logic [8*COORD_BITS-1:0] in_data,
    output logic                         out_valid,
    output logic [NW-1:0]                num_a,
    output logic [NW-1:0]                num_b,
    output logic [NW-1:0]                num_c,
    output logic [UW-1:0]                den,
    output logic [2:0]                   neg,
    output logic                         degen
);

    logic signed [COORD_BITS-1:0] crd [8];
    logic signed [DW-1:0] e1x_next, e1y_next, e2x_next, e2y_next, dx_next, dy_next;
    logic signed [DW-1:0] e1x_reg, e1y_reg, e2x_reg, e2y_reg, dx_reg, dy_reg;
    logic signed [PW-1:0] p_reg [6];
    logic signed [UW-1:0] ux_next, uy_next, uz_next;
    logic signed [UW-1:0] ux_reg, uy_reg, uz_reg;
    logic signed [SW-1:0] s_next, s_reg;
    logic [UW-1:0] mag_ux, mag_uy, mag_uz;
    logic [SW-1:0] mag_s;
    logic [2:0] v_reg;
    logic v4_reg;
    logic [NW-1:0] na_reg, nb_reg, nc_reg;
    logic [UW-1:0] den_reg;
    logic [2:0] neg_reg;
    logic degen_reg;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            crd[i] = $signed(in_data[i*COORD_BITS +: COORD_BITS]);
        end
        e1x_next = DW'(crd[2]) - DW'(crd[0]);
        e1y_next = DW'(crd[3]) - DW'(crd[1]);
        e2x_next = DW'(crd[4]) - DW'(crd[0]);
        e2y_next = DW'(crd[5]) - DW'(crd[1]);
        dx_next  = DW'(crd[0]) - DW'(crd[6]);
        dy_next  = DW'(crd[1]) - DW'(crd[7]);
        ux_next  = UW'(p_reg[0]) - UW'(p_reg[1]);
        uy_next  = UW'(p_reg[2]) - UW'(p_reg[3]);
        uz_next  = UW'(p_reg[4]) - UW'(p_reg[5]);
        s_next   = SW'(p_reg[0]) - SW'(p_reg[1]) + SW'(p_reg[2]) - SW'(p_reg[3]);
        mag_ux   = ux_reg[UW-1] ? UW'(-ux_reg) : UW'(ux_reg);
        mag_uy   = uy_reg[UW-1] ? UW'(-uy_reg) : UW'(uy_reg);
        mag_uz   = uz_reg[UW-1] ? UW'(-uz_reg) : UW'(uz_reg);
        mag_s    = s_reg[SW-1] ? SW'(-s_reg) : SW'(s_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg  <= '0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v_reg  <= {v_reg[1:0], in_valid};
            v4_reg <= v_reg[2];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e1x_reg <= e1x_next;
            e1y_reg <= e1y_next;
            e2x_reg <= e2x_next;
            e2y_reg <= e2y_next;
            dx_reg  <= dx_next;
            dy_reg  <= dy_next;
            p_reg[0] <= PW'(e2x_reg) * PW'(dy_reg);
            p_reg[1] <= PW'(dx_reg) * PW'(e2y_reg);
            p_reg[2] <= PW'(dx_reg) * PW'(e1y_reg);
            p_reg[3] <= PW'(e1x_reg) * PW'(dy_reg);
            p_reg[4] <= PW'(e1x_reg) * PW'(e2y_reg);
            p_reg[5] <= PW'(e2x_reg) * PW'(e1y_reg);
            ux_reg <= ux_next;
            uy_reg <= uy_next;
            uz_reg <= uz_next;
            s_reg  <= s_next;
            nb_reg <= NW'({mag_ux, {FRAC_BITS{1'b0}}});
            nc_reg <= NW'({mag_uy, {FRAC_BITS{1'b0}}});
            na_reg <= {mag_s, {FRAC_BITS{1'b0}}};
            den_reg <= mag_uz;
            neg_reg <= {s_reg[SW-1] ^ uz_reg[UW-1], uy_reg[UW-1] ^ uz_reg[UW-1],
                        ux_reg[UW-1] ^ uz_reg[UW-1]};
            degen_reg <= (uz_reg == '0);
        end
    end

    assign out_valid = v4_reg;
    assign num_a     = na_reg;
    assign num_b     = nb_reg;
    assign num_c     = nc_reg;
    assign den       = den_reg;
    assign neg       = neg_reg;
    assign degen     = degen_reg;

endmodule : bwu_front

`default_nettype wire

// ===== rtl/bwu_div.sv =====
// ----------------------------------------------------------------------------
// Barycentric weights divider
// Pipelined restoring unsigned divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module bwu_div import bwu_pkg::*; #(
    parameter int NW = 44,
    parameter int DENW = 27
) (
    input  wire logic            aclk,
    input  wire logic            en,
    input  wire logic [NW-1:0]   num,
    input  wire logic [DENW-1:0] den,
    output logic [NW-1:0]        quo
);

    logic [NW-1:0]   n_reg [NW+1];
    logic [DENW-1:0] r_reg [NW+1];
    logic [DENW-1:0] d_reg [NW+1];

    assign n_reg[0] = num;
    assign r_reg[0] = '0;
    assign d_reg[0] = den;

    for (genvar k = 0; k < NW; k++) begin : g_step
        logic [DENW:0] trial;
        logic [DENW:0] diff;
        logic          ge;

        always_comb begin
            trial = {r_reg[k], n_reg[k][NW-1]};
            diff  = trial - {1'b0, d_reg[k]};
            ge    = !diff[DENW];
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[k+1] <= ge ? diff[DENW-1:0] : trial[DENW-1:0];
                n_reg[k+1] <= {n_reg[k][NW-2:0], ge};
                d_reg[k+1] <= d_reg[k];
            end
        end
    end

    assign quo = n_reg[NW];

endmodule : bwu_div

`default_nettype wire

// ===== rtl/barycentric_weights_unit.sv =====
// ----------------------------------------------------------------------------
// Barycentric weights unit
// Planar barycentric weights of a point against a screen triangle.
// ----------------------------------------------------------------------------
// The unit accepts one item per clock while the output is not stalled and passes each
// item through 4 + (2*COORD_BITS + 4 + FRAC_BITS) + 1 register stages, which is 49
// stages at the default sizes; the depth is set by the divider, which resolves one
// quotient bit per stage. A stall at the output freezes the whole pipeline, and the
// input is ready whenever the output register is empty or being read.
`default_nettype none

module barycentric_weights_unit import bwu_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    // a_x, a_y, b_x, b_y, c_x, c_y, p_x, p_y
    input  wire logic [8*COORD_BITS-1:0] s_tdata,
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    // weight_a, weight_b, weight_c
    output logic [3*WEIGHT_BITS-1:0]     m_tdata,
    // degenerate
    output logic                         m_tuser
);

    localparam int DW = COORD_BITS + 1;
    localparam int UW = 2 * DW + 1;
    localparam int SW = UW + 1;
    localparam int NW = SW + FRAC_BITS;
    localparam int XW = (NW + 2 > WEIGHT_BITS + 2) ? NW + 2 : WEIGHT_BITS + 2;
    localparam logic signed [XW-1:0] W_MAX = XW'((64'sd1 <<< (WEIGHT_BITS - 1)) - 1);
    localparam logic signed [XW-1:0] W_MIN = -XW'(64'sd1 <<< (WEIGHT_BITS - 1));
    localparam logic signed [XW-1:0] ONE   = XW'(64'sd1 <<< FRAC_BITS);

    logic en;
    logic f_valid, f_degen;
    logic [NW-1:0] num_a, num_b, num_c, q_a, q_b, q_c;
    logic [UW-1:0] den;
    logic [2:0] f_neg;
    logic [NW:0] v_reg;
    logic [2:0] neg_reg [NW+1];
    logic dg_reg [NW+1];
    logic signed [XW-1:0] sa, sb, sc, wa, wb, wc;
    logic [WEIGHT_BITS-1:0] wa_next, wb_next, wc_next;
    logic m_valid_reg, m_degen_reg;
    logic [3*WEIGHT_BITS-1:0] m_data_reg;

    assign en       = m_tready || !m_valid_reg;
    assign s_tready = en;

    bwu_front #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_front (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(s_tvalid),
        .in_data(s_tdata), .out_valid(f_valid), .num_a(num_a), .num_b(num_b),
        .num_c(num_c), .den(den), .neg(f_neg), .degen(f_degen)
    );

    bwu_div #(.NW(NW), .DENW(UW)) u_div_a (
        .aclk(aclk), .en(en), .num(num_a), .den(den), .quo(q_a)
    );
    bwu_div #(.NW(NW), .DENW(UW)) u_div_b (
        .aclk(aclk), .en(en), .num(num_b), .den(den), .quo(q_b)
    );
    bwu_div #(.NW(NW), .DENW(UW)) u_div_c (
        .aclk(aclk), .en(en), .num(num_c), .den(den), .quo(q_c)
    );

    assign v_reg[0]   = f_valid;
    assign neg_reg[0] = f_neg;
    assign dg_reg[0]  = f_degen;

    for (genvar k = 0; k < NW; k++) begin : g_tag
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k+1] <= 1'b0;
            end else if (en) begin
                v_reg[k+1] <= v_reg[k];
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                neg_reg[k+1] <= neg_reg[k];
                dg_reg[k+1]  <= dg_reg[k];
            end
        end
    end

    always_comb begin
        sa = neg_reg[NW][2] ? -XW'(q_a) : XW'(q_a);
        sb = neg_reg[NW][0] ? -XW'(q_b) : XW'(q_b);
        sc = neg_reg[NW][1] ? -XW'(q_c) : XW'(q_c);
        wa = ONE - sa;
        wb = sb;
        wc = sc;
        wa_next = (wa > W_MAX) ? W_MAX[WEIGHT_BITS-1:0] :
                  (wa < W_MIN) ? W_MIN[WEIGHT_BITS-1:0] : wa[WEIGHT_BITS-1:0];
        wb_next = (wb > W_MAX) ? W_MAX[WEIGHT_BITS-1:0] :
                  (wb < W_MIN) ? W_MIN[WEIGHT_BITS-1:0] : wb[WEIGHT_BITS-1:0];
        wc_next = (wc > W_MAX) ? W_MAX[WEIGHT_BITS-1:0] :
                  (wc < W_MIN) ? W_MIN[WEIGHT_BITS-1:0] : wc[WEIGHT_BITS-1:0];
        if (dg_reg[NW]) begin
            wa_next = WEIGHT_BITS'(-ONE);
            wb_next = ONE[WEIGHT_BITS-1:0];
            wc_next = ONE[WEIGHT_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= v_reg[NW];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg  <= {wc_next, wb_next, wa_next};
            m_degen_reg <= dg_reg[NW];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_degen_reg;

`ifndef SYNTHESIS
    a_ready_follows_output: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (m_tready || !m_tvalid))
        else $error("input ready does not follow the output register");
    a_degen_weights: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[WEIGHT_BITS +: WEIGHT_BITS] == ONE[WEIGHT_BITS-1:0])
        else $error("degenerate item carries wrong weight");
    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");
`endif

endmodule : barycentric_weights_unit

`default_nettype wire

// ===== tb/sv/barycentric_weights_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Barycentric weights unit testbench
// Drives coordinate items from a directed table and then at random, under
// several patterns of sender gaps and receiver stalls, and checks every
// returned item against a local computation of the weights.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module barycentric_weights_unit_tb;
    import bwu_pkg::*;

    localparam int CB = COORD_BITS_DEF;
    localparam int FB = FRAC_BITS_DEF;
    localparam int NUM_RANDOM = 1200;
    localparam int SETTLE_CYCLES = 80;
    localparam int STALL_LIMIT = 5000;
    localparam longint ONE = longint'(1) << FB;
    localparam longint WMAX = 64'sd2147483647;
    localparam longint WMIN = -64'sd2147483648;

    typedef logic signed [CB-1:0] coord_t;
    typedef logic signed [WEIGHT_BITS-1:0] weight_t;

    typedef struct packed {
        coord_t ax, ay, bx, by, cx, cy, px, py;
    } tri_t;

    typedef struct packed {
        weight_t wa, wb, wc;
        logic degen;
    } weights_t;

    typedef struct {
        tri_t t;
        bit known;
        weights_t w;
    } row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [8*CB-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [3*WEIGHT_BITS-1:0] m_tdata;
    logic m_tuser;

    weights_t pending_weights[$];
    int errors = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;

    always #2 aclk = ~aclk;

    barycentric_weights_unit i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    function automatic longint clamp32(longint v);
        if (v > WMAX) return WMAX;
        if (v < WMIN) return WMIN;
        return v;
    endfunction

    function automatic weights_t compute_weights(tri_t t);
        longint e1x, e1y, e2x, e2y, dx, dy, ux, uy, uz;
        weights_t w;
        e1x = longint'(t.bx) - longint'(t.ax);
        e1y = longint'(t.by) - longint'(t.ay);
        e2x = longint'(t.cx) - longint'(t.ax);
        e2y = longint'(t.cy) - longint'(t.ay);
        dx = longint'(t.ax) - longint'(t.px);
        dy = longint'(t.ay) - longint'(t.py);
        ux = e2x * dy - dx * e2y;
        uy = dx * e1y - e1x * dy;
        uz = e1x * e2y - e2x * e1y;
        if (uz == 0) begin
            w.wa = weight_t'(-ONE);
            w.wb = weight_t'(ONE);
            w.wc = weight_t'(ONE);
            w.degen = 1'b1;
        end else begin
            w.wb = weight_t'(clamp32((ux * ONE) / uz));
            w.wc = weight_t'(clamp32((uy * ONE) / uz));
            w.wa = weight_t'(clamp32(ONE - ((ux + uy) * ONE) / uz));
            w.degen = 1'b0;
        end
        return w;
    endfunction

    function automatic logic [8*CB-1:0] pack_tri(tri_t t);
        return {t.py, t.px, t.cy, t.cx, t.by, t.bx, t.ay, t.ax};
    endfunction

    function automatic coord_t rnd_coord(int span);
        return coord_t'($urandom_range(2 * span) - span);
    endfunction

    function automatic tri_t random_tri();
        tri_t t;
        int kind;
        kind = $urandom_range(99);
        t = tri_t'({$urandom, $urandom, $urandom});
        if (kind >= 60 && kind < 80) begin
            t.ax = rnd_coord(40); t.ay = rnd_coord(40);
            t.bx = rnd_coord(40); t.by = rnd_coord(40);
            t.cx = rnd_coord(40); t.cy = rnd_coord(40);
            t.px = rnd_coord(60); t.py = rnd_coord(60);
        end else if (kind >= 80 && kind < 95) begin
            // Collinear vertices: C mirrors A about B.
            t.ax = rnd_coord(600); t.ay = rnd_coord(600);
            t.bx = rnd_coord(600); t.by = rnd_coord(600);
            t.cx = coord_t'(2 * t.bx - t.ax);
            t.cy = coord_t'(2 * t.by - t.ay);
        end else if (kind >= 95) begin
            // Sliver triangle of half-unit area drives the weights into clamping.
            t.bx = coord_t'(t.ax + 1);
            t.by = t.ay;
            t.cy = coord_t'(t.ay + 1);
        end
        return t;
    endfunction

    task automatic send_item(tri_t t);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = pack_tri(t);
        do @(posedge aclk); while (!s_tready);
        pending_weights.push_back(compute_weights(t));
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic drain();
        while (pending_weights.size() != 0) @(negedge aclk);
    endtask

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        weights_t got, want;
        if (m_tvalid && m_tready) begin
            got = {m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tuser};
            if (pending_weights.size() == 0) begin
                $error("unexpected item: wa=%0d wb=%0d wc=%0d degen=%0b",
                       got.wa, got.wb, got.wc, got.degen);
                errors++;
            end else begin
                want = pending_weights.pop_front();
                if (got.wa !== want.wa) begin
                    $error("weight_a: expected %0d, got %0d", want.wa, got.wa);
                    errors++;
                end
                if (got.wb !== want.wb) begin
                    $error("weight_b: expected %0d, got %0d", want.wb, got.wb);
                    errors++;
                end
                if (got.wc !== want.wc) begin
                    $error("weight_c: expected %0d, got %0d", want.wc, got.wc);
                    errors++;
                end
                if (got.degen !== want.degen) begin
                    $error("degenerate: expected %0b, got %0b", want.degen, got.degen);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (aresetn) begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    function automatic row_t mk_row(int ax, int ay, int bx, int by, int cx, int cy,
                                    int px, int py, bit known = 0,
                                    int wa = 0, int wb = 0, int wc = 0, bit dg = 0);
        row_t r;
        r.t = '{coord_t'(ax), coord_t'(ay), coord_t'(bx), coord_t'(by),
                coord_t'(cx), coord_t'(cy), coord_t'(px), coord_t'(py)};
        r.known = known;
        r.w = '{weight_t'(wa), weight_t'(wb), weight_t'(wc), dg};
        return r;
    endfunction

    initial begin
        row_t rows[$];
        weights_t calc;
        rows.push_back(mk_row(0, 0, 0, 0, 0, 0, 0, 0, 1, -65536, 65536, 65536, 1));
        rows.push_back(mk_row(-2048, -2048, -2048, -2048, -2048, -2048, 2047, 2047,
                              1, -65536, 65536, 65536, 1));
        rows.push_back(mk_row(2047, 2047, 2047, 2047, 2047, 2047, -2048, -2048,
                              1, -65536, 65536, 65536, 1));
        rows.push_back(mk_row(0, 0, 1, 0, 0, 1, 0, 0, 1, 65536, 0, 0, 0));
        rows.push_back(mk_row(0, 0, 1, 0, 0, 1, 1, 0, 1, 0, 65536, 0, 0));
        rows.push_back(mk_row(0, 0, 1, 0, 0, 1, 0, 1, 1, 0, 0, 65536, 0));
        rows.push_back(mk_row(-2048, -2048, 2047, -2048, -2048, 2047, 0, 0));
        rows.push_back(mk_row(-2048, -2048, 2047, -2048, -2048, 2047, 2047, 2047));
        rows.push_back(mk_row(-2048, -2048, -2047, -2048, 2047, -2047, 2047, 2047));
        rows.push_back(mk_row(2047, 2047, 2046, 2047, -2048, 2046, -2048, -2048));
        rows.push_back(mk_row(-2048, -2048, -2047, -2048, 2047, -2047, -2048, 2047));
        rows.push_back(mk_row(0, 0, 1, 0, 0, -1, 2047, -2048));
        rows.push_back(mk_row(-2048, 2047, 2047, -2048, 2047, 2047, -2048, -2048));
        rows.push_back(mk_row(-1, -1, 5, 3, -7, 9, 2, 2));
        rows.push_back(mk_row(10, 10, 20, 20, 30, 30, 15, 40, 1, -65536, 65536, 65536, 1));
        rows.push_back(mk_row(-1365, 1365, 1365, -1365, 0, 0, -1, 1));

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (rows[i]) begin
            calc = compute_weights(rows[i].t);
            if (rows[i].known && calc !== rows[i].w) begin
                $error("directed row %0d: table and computed weights disagree", i);
                errors++;
            end
            send_item(rows[i].t);
        end
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            idle_pct = (phase == 1 || phase == 3) ? ((phase == 3) ? 26 : 45) : 0;
            stall_pct = (phase == 2 || phase == 3) ? ((phase == 3) ? 26 : 45) : 0;
            for (int n = 0; n < NUM_RANDOM / 4; n++) begin
                if (n == NUM_RANDOM / 8) drain();
                send_item(random_tri());
            end
        end
        stall_pct = 0;
        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire
